FILE: hw/rtl/keyed_table_lru_by_timestamp_unit_assert.svh
// Assertion macros for the keyed table unit.
`ifndef KEYED_TABLE_LRU_BY_TIMESTAMP_UNIT_ASSERT_SVH
`define KEYED_TABLE_LRU_BY_TIMESTAMP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KLTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KLTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/kltu_pkg.sv
// Shared types and constants for the keyed table unit.
package kltu_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W      = 64;
    localparam int TIME_W     = 64;
    localparam int INTERVAL_W = 32;
    localparam int ACTION_W   = 3;
    localparam int SLOT_W     = 4;
    localparam int FILL_W     = 5;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 32'd3600;
    localparam logic [TIME_W-1:0]     SIGN_BIAS    = {1'b1, {(TIME_W-1){1'b0}}};

    localparam logic [ACTION_W-1:0] ACT_IGNORE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_HIT     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REFRESH = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_EVICT   = 3'd4;

    typedef struct packed {
        logic signed [KEY_W-1:0]  entry_key;
        logic signed [TIME_W-1:0] event_time;
    } t_in;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [SLOT_W-1:0]       slot_index;
        logic signed [KEY_W-1:0] evicted_key;
        logic [FILL_W-1:0]       fill_count;
    } t_out;

endpackage

FILE: hw/rtl/keyed_table_lru_by_timestamp_unit.sv
// Top level of the keyed table with least-recently-stamped replacement.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries a signed
//   64-bit key and a signed 64-bit event time. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns one result per input transfer: action,
//   slot, evicted key and fill count. i_cfg_we / i_cfg_wdata write the touch
//   interval; write it only while the block is idle.
// Sequence:
//   One item at a time. The table RAM is read one entry per cycle through
//   its registered read port and the match/minimum compare runs on each
//   returned entry; a miss scans up to the fill count, a hit stops at the
//   matching slot. Key zero skips the scan. o_in_ready rises together with
//   o_out_valid when the result is loaded into the output register.
// Reset:
//   Synchronous, active low. Empties the table (fill count 0), restores the
//   touch interval to 3600 and drops any pending result. RAM contents are not
//   cleared; entries at or above the fill count are never read.
// Stall:
//   The result sits in an output register. A new item is accepted while it
//   waits; the next result is held inside until the output register frees.
module keyed_table_lru_by_timestamp_unit #(
    parameter int ENTRIES = kltu_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  kltu_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output kltu_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [kltu_pkg::INTERVAL_W-1:0]     i_cfg_wdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;  // slot index width
    localparam int CW = $clog2(ENTRIES + 1);                   // count width
    localparam int KW = kltu_pkg::KEY_W;
    localparam int TW = kltu_pkg::TIME_W;
    localparam int RW = KW + TW;

    localparam logic [CW-1:0] COUNT_FULL = CW'(ENTRIES);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;   // stream entries through compare
    localparam logic [2:0] S_HIT  = 3'd2;   // interval check and refresh
    localparam logic [2:0] S_MISS = 3'd3;   // insert or evict
    localparam logic [2:0] S_DONE = 3'd4;   // hand result to output register

    // Control registers
    logic [2:0]                         r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [CW-1:0]                      r_ridx, n_ridx;       // next read address
    logic                               r_pend, n_pend;       // read data due
    logic                               r_out_valid, n_out_valid;
    logic [kltu_pkg::INTERVAL_W-1:0]    r_touch, n_touch;

    // Payload registers
    logic [KW-1:0]                      r_key, n_key;
    logic [TW-1:0]                      r_time, n_time;
    logic [IW-1:0]                      r_pidx, n_pidx;       // index of read data
    logic [IW-1:0]                      r_hit_idx, n_hit_idx;
    logic [TW-1:0]                      r_hit_stamp, n_hit_stamp;
    logic [IW-1:0]                      r_best_idx, n_best_idx;
    logic [TW-1:0]                      r_best_bstamp, n_best_bstamp;  // biased
    logic [KW-1:0]                      r_best_key, n_best_key;
    kltu_pkg::t_out                     r_res, n_res;
    kltu_pkg::t_out                     r_out, n_out;

    // RAM port signals
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [RW-1:0]      ram_rdata;

    logic [KW-1:0]      rd_key;
    logic [TW-1:0]      rd_bstamp;
    logic [TW:0]        stamp_sum;     // biased stamp + interval, one carry bit
    logic               refresh;
    logic               in_xfer;

    kltu_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign rd_key    = ram_rdata[RW-1:TW];
    assign rd_bstamp = ram_rdata[TW-1:0] ^ kltu_pkg::SIGN_BIAS;
    assign ram_raddr = r_ridx[IW-1:0];

    // No-wrap interval test: a carry out means the sum left the signed range.
    assign stamp_sum = {1'b0, r_hit_stamp ^ kltu_pkg::SIGN_BIAS}
                     + {{(TW + 1 - kltu_pkg::INTERVAL_W){1'b0}}, r_touch};
    assign refresh   = !stamp_sum[TW]
                     && ((r_time ^ kltu_pkg::SIGN_BIAS) > stamp_sum[TW-1:0]);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ridx        = r_ridx;
        n_pend        = r_pend;
        n_out_valid   = r_out_valid;
        n_touch       = r_touch;
        n_key         = r_key;
        n_time        = r_time;
        n_pidx        = r_pidx;
        n_hit_idx     = r_hit_idx;
        n_hit_stamp   = r_hit_stamp;
        n_best_idx    = r_best_idx;
        n_best_bstamp = r_best_bstamp;
        n_best_key    = r_best_key;
        n_res         = r_res;
        n_out         = r_out;
        ram_we        = 1'b0;
        ram_waddr     = r_hit_idx;
        ram_wdata     = {r_key, r_time};

        if (i_cfg_we) begin
            n_touch = i_cfg_wdata;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_key  = i_in_data.entry_key;
                    n_time = i_in_data.event_time;
                    n_ridx = '0;
                    n_pend = 1'b0;
                    if (i_in_data.entry_key == '0) begin
                        n_res.action      = kltu_pkg::ACT_IGNORE;
                        n_res.slot_index  = '0;
                        n_res.evicted_key = '0;
                        n_res.fill_count  = kltu_pkg::FILL_W'(r_count);
                        n_state           = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue side: one read per cycle up to the fill count
                if (r_ridx < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_ridx[IW-1:0];
                    n_ridx = r_ridx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                // compare side: data of the read issued last cycle
                if (r_pend) begin
                    if (rd_key == r_key) begin
                        n_hit_idx   = r_pidx;
                        n_hit_stamp = ram_rdata[TW-1:0];
                        n_pend      = 1'b0;
                        n_state     = S_HIT;
                    end else if ((r_pidx == '0) || (rd_bstamp < r_best_bstamp)) begin
                        // strict less-than keeps the lowest index on ties
                        n_best_idx    = r_pidx;
                        n_best_bstamp = rd_bstamp;
                        n_best_key    = rd_key;
                    end
                end else if (r_ridx >= r_count) begin
                    n_state = S_MISS;
                end
            end
            S_HIT: begin
                n_res.slot_index  = kltu_pkg::SLOT_W'(r_hit_idx);
                n_res.evicted_key = '0;
                n_res.fill_count  = kltu_pkg::FILL_W'(r_count);
                if (refresh) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_hit_idx;
                    n_res.action = kltu_pkg::ACT_REFRESH;
                end else begin
                    n_res.action = kltu_pkg::ACT_HIT;
                end
                n_state = S_DONE;
            end
            S_MISS: begin
                ram_we = 1'b1;
                if (r_count < COUNT_FULL) begin
                    ram_waddr         = r_count[IW-1:0];
                    n_count           = r_count + CW'(1);
                    n_res.action      = kltu_pkg::ACT_INSERT;
                    n_res.slot_index  = kltu_pkg::SLOT_W'(r_count);
                    n_res.evicted_key = '0;
                    n_res.fill_count  = kltu_pkg::FILL_W'(r_count + CW'(1));
                end else begin
                    ram_waddr         = r_best_idx;
                    n_res.action      = kltu_pkg::ACT_EVICT;
                    n_res.slot_index  = kltu_pkg::SLOT_W'(r_best_idx);
                    n_res.evicted_key = r_best_key;
                    n_res.fill_count  = kltu_pkg::FILL_W'(r_count);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ridx      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_touch     <= kltu_pkg::INTERVAL_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ridx      <= n_ridx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_touch     <= n_touch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_time        <= n_time;
        r_pidx        <= n_pidx;
        r_hit_idx     <= n_hit_idx;
        r_hit_stamp   <= n_hit_stamp;
        r_best_idx    <= n_best_idx;
        r_best_bstamp <= n_best_bstamp;
        r_best_key    <= n_best_key;
        r_res         <= n_res;
        r_out         <= n_out;
    end

`include "keyed_table_lru_by_timestamp_unit_assert.svh"

    `KLTU_ASSERT_NOW(a_count_bound, 1'b1, r_count <= COUNT_FULL, "fill count above table size")
    `KLTU_ASSERT_NOW(a_evict_full, r_out_valid && (r_out.action == kltu_pkg::ACT_EVICT), r_count == COUNT_FULL, "eviction reported on a table that is not full")
    `KLTU_ASSERT_NEXT(a_insert_grows, (r_state == S_MISS) && (r_count < COUNT_FULL), r_count == $past(r_count) + CW'(1), "free-slot insert did not grow the fill count")
    `KLTU_ASSERT_NEXT(a_accept_start, in_xfer, (r_state == S_SCAN) || (r_state == S_DONE), "accepted item did not start processing")

endmodule

FILE: hw/rtl/kltu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kltu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
